// ===== src/swrl_pkg.sv =====
`timescale 1ns / 1ps

package swrl_pkg;

  // field widths
  localparam int unsigned SecW    = 32;
  localparam int unsigned MillisW = 10;
  localparam int unsigned CntW    = 16;

  // reset value of the rate limit
  localparam logic [CntW-1:0] MaxRateRst = 16'd100;

  // division by 1000 through a reciprocal: exact for dividends below 2**ProdW
  localparam int unsigned ProdW    = 20;
  localparam int unsigned DivShift = 30;
  localparam int unsigned DivMulW  = 21;
  localparam logic [DivMulW-1:0] DivMul = 21'd1073742;
  localparam int unsigned QuotW    = 11;

  // sequencer states
  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_DIV1   = 7'b0000010,
    ST_DIV2   = 7'b0000100,
    ST_DECIDE = 7'b0001000,
    ST_CLEAR  = 7'b0010000,
    ST_WALK   = 7'b0100000,
    ST_OUT    = 7'b1000000
  } state_e;

  // how the current request relates to the stored rows
  typedef enum logic [1:0] {
    MODE_FIRST = 2'd0,
    MODE_SAME  = 2'd1,
    MODE_NEXT  = 2'd2,
    MODE_GAP   = 2'd3
  } mode_e;

endpackage

// ===== src/swrl_slot_idx.sv =====
`timescale 1ns / 1ps

module swrl_slot_idx #(
  parameter int unsigned SLOTS = 10,
  parameter int unsigned SW    = 4
) (
  input  logic                         clk_i,
  input  logic [swrl_pkg::MillisW-1:0] millis_i,
  output logic [SW-1:0]                slot_o
);

  localparam int unsigned MulW = swrl_pkg::ProdW + swrl_pkg::DivMulW;

  logic [swrl_pkg::ProdW-1:0] prod_q;
  logic [swrl_pkg::ProdW-1:0] prod_d;
  logic [MulW-1:0]            recip;
  logic [swrl_pkg::QuotW-1:0] quot;
  logic [SW-1:0]              slot_q;
  logic [SW-1:0]              slot_d;

  // first stage: millis scaled by the slot count
  assign prod_d = swrl_pkg::ProdW'(millis_i) * swrl_pkg::ProdW'(SLOTS);

  // second stage: divide by 1000 and saturate at the last slot
  assign recip = MulW'(prod_q) * MulW'(swrl_pkg::DivMul);
  assign quot  = recip[swrl_pkg::DivShift +: swrl_pkg::QuotW];

  always_comb begin
    if (quot > swrl_pkg::QuotW'(SLOTS - 1)) begin
      slot_d = SW'(SLOTS - 1);
    end else begin
      slot_d = quot[SW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    slot_q <= slot_d;
  end

  assign slot_o = slot_q;

endmodule

// ===== src/swrl_cnt_mem.sv =====
`timescale 1ns / 1ps

module swrl_cnt_mem #(
  parameter int unsigned DEPTH = 20,
  parameter int unsigned AW    = 5
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [AW-1:0]             waddr_i,
  input  logic [swrl_pkg::CntW-1:0] wdata_i,
  input  logic [AW-1:0]             raddr_i,
  output logic [swrl_pkg::CntW-1:0] rdata_o
);

  logic [swrl_pkg::CntW-1:0] mem_q [DEPTH];
  logic [swrl_pkg::CntW-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/sliding_window_rate_limiter_unit.sv =====
`timescale 1ns / 1ps

// channel  | direction | handshake                      | beat
// ---------+-----------+--------------------------------+---------------------------
// in       | input     | in_valid_i / in_stall_o        | seconds_i, millis_i
// out      | output    | out_valid_o / out_stall_i      | allowed_o, window_count_o
// cfg      | input     | cfg_valid_i / cfg_ready_o      | cfg_max_rate_i
//
// one request at a time; after the accepting edge ST_DIV1 and ST_DIV2 compute the slot
// index and ST_DECIDE picks the case, then per case: same second a window walk, next
// second a clear of the new row plus a walk of the old row's later slots, other gaps and
// the first request a clear of both rows; ST_OUT then hands the beat to the output
// register, waiting while a held result still sits there.
// the counter memory, one read and one write per cycle, sets the pace.
// no clearing pass after reset: the first request clears both rows.
// a held result in the output register does not block the next input beat.

module sliding_window_rate_limiter_unit #(
  parameter int unsigned SLOTS = 10
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [swrl_pkg::SecW-1:0]    seconds_i,
  input  logic [swrl_pkg::MillisW-1:0] millis_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         allowed_o,
  output logic [swrl_pkg::CntW-1:0]    window_count_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [swrl_pkg::CntW-1:0]    cfg_max_rate_i
);

  localparam int unsigned Depth = 2 * SLOTS;
  localparam int unsigned SW    = $clog2(SLOTS);
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned CW    = $clog2(Depth + 1);
  localparam int unsigned RW    = $clog2(SLOTS + 1);
  localparam int unsigned CntW  = swrl_pkg::CntW;
  localparam int unsigned SecW  = swrl_pkg::SecW;

  // control state
  swrl_pkg::state_e state_q, state_d;
  logic             in_use_q, in_use_d;
  logic             cur_row_q, cur_row_d;
  logic [CntW-1:0]  max_rate_q, max_rate_d;
  logic             out_valid_q, out_valid_d;
  logic             rd_pend_q, rd_pend_d;

  // datapath registers
  swrl_pkg::mode_e  mode_q, mode_d;
  logic [SecW-1:0]  row_sec_q [2];
  logic [SecW-1:0]  row_sec_d [2];
  logic [SecW-1:0]  secs_q, secs_d;
  logic [swrl_pkg::MillisW-1:0] millis_q, millis_d;
  logic [AW-1:0]    clr_addr_q, clr_addr_d;
  logic [CW-1:0]    clr_left_q, clr_left_d;
  logic [AW-1:0]    rd_addr_q, rd_addr_d;
  logic [RW-1:0]    rd_left_q, rd_left_d;
  logic             first_q, first_d;
  logic [CntW-1:0]  sum_q, sum_d;
  logic [CntW-1:0]  cur_val_q, cur_val_d;
  logic             res_allowed_q, res_allowed_d;
  logic [CntW-1:0]  res_count_q, res_count_d;
  logic             do_write_q, do_write_d;
  logic [AW-1:0]    wr_addr_q, wr_addr_d;
  logic [CntW-1:0]  wr_data_q, wr_data_d;
  logic             out_allowed_q, out_allowed_d;
  logic [CntW-1:0]  out_count_q, out_count_d;

  // memory port and helpers
  logic [SW-1:0]    slot;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [CntW-1:0]  mem_wdata;
  logic [CntW-1:0]  mem_rdata;
  logic [CntW-1:0]  sum_new;
  logic [CntW-1:0]  cur_val_eff;
  logic [AW-1:0]    base_cur;
  logic [AW-1:0]    base_oth;
  logic [SecW-1:0]  sec_diff;
  logic             out_free;

  swrl_slot_idx #(
    .SLOTS (SLOTS),
    .SW    (SW)
  ) u_slot_idx (
    .clk_i    (clk_i),
    .millis_i (millis_q),
    .slot_o   (slot)
  );

  swrl_cnt_mem #(
    .DEPTH (Depth),
    .AW    (AW)
  ) u_cnt_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (rd_addr_q),
    .rdata_o (mem_rdata)
  );

  // row bases and window arithmetic
  assign base_cur    = cur_row_q ? AW'(SLOTS) : '0;
  assign base_oth    = cur_row_q ? '0 : AW'(SLOTS);
  assign sec_diff    = secs_q - row_sec_q[cur_row_q];
  assign sum_new     = sum_q + mem_rdata;
  assign cur_val_eff = (first_q && rd_pend_q) ? mem_rdata : cur_val_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  // sequencer
  always_comb begin
    state_d       = state_q;
    in_use_d      = in_use_q;
    cur_row_d     = cur_row_q;
    max_rate_d    = max_rate_q;
    out_valid_d   = out_valid_q;
    rd_pend_d     = 1'b0;
    mode_d        = mode_q;
    row_sec_d     = row_sec_q;
    secs_d        = secs_q;
    millis_d      = millis_q;
    clr_addr_d    = clr_addr_q;
    clr_left_d    = clr_left_q;
    rd_addr_d     = rd_addr_q;
    rd_left_d     = rd_left_q;
    first_d       = first_q;
    sum_d         = sum_q;
    cur_val_d     = cur_val_q;
    res_allowed_d = res_allowed_q;
    res_count_d   = res_count_q;
    do_write_d    = do_write_q;
    wr_addr_d     = wr_addr_q;
    wr_data_d     = wr_data_q;
    out_allowed_d = out_allowed_q;
    out_count_d   = out_count_q;
    mem_we        = 1'b0;
    mem_waddr     = wr_addr_q;
    mem_wdata     = wr_data_q;

    // config write
    if (cfg_valid_i) begin
      max_rate_d = cfg_max_rate_i;
    end

    // output beat taken
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      swrl_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          secs_d   = seconds_i;
          millis_d = millis_i;
          state_d  = swrl_pkg::ST_DIV1;
        end
      end

      swrl_pkg::ST_DIV1: begin
        state_d = swrl_pkg::ST_DIV2;
      end

      swrl_pkg::ST_DIV2: begin
        state_d = swrl_pkg::ST_DECIDE;
      end

      swrl_pkg::ST_DECIDE: begin
        sum_d   = '0;
        first_d = 1'b0;
        if (!in_use_q) begin
          // first request: clear everything, the window is empty
          in_use_d      = 1'b1;
          cur_row_d     = 1'b0;
          row_sec_d[0]  = secs_q;
          row_sec_d[1]  = secs_q;
          mode_d        = swrl_pkg::MODE_FIRST;
          clr_addr_d    = '0;
          clr_left_d    = CW'(Depth);
          wr_addr_d     = AW'(slot);
          wr_data_d     = CntW'(1);
          res_allowed_d = 1'b1;
          do_write_d    = (max_rate_q != '0);
          res_count_d   = (max_rate_q != '0) ? CntW'(1) : '0;
          state_d       = swrl_pkg::ST_CLEAR;
        end else if (secs_q == row_sec_q[cur_row_q]) begin
          // same second: walk back from the slot across both rows
          mode_d    = swrl_pkg::MODE_SAME;
          rd_addr_d = base_cur + AW'(slot);
          rd_left_d = RW'(SLOTS);
          first_d   = 1'b1;
          wr_addr_d = base_cur + AW'(slot);
          state_d   = swrl_pkg::ST_WALK;
        end else if (sec_diff == SecW'(1)) begin
          // next second: swap rows, clear the new one, walk the old tail
          mode_d                = swrl_pkg::MODE_NEXT;
          cur_row_d             = !cur_row_q;
          row_sec_d[!cur_row_q] = secs_q;
          clr_addr_d            = base_oth;
          clr_left_d            = CW'(SLOTS);
          rd_addr_d             = base_cur + AW'(SLOTS - 1);
          rd_left_d             = RW'(SLOTS - 1) - RW'(slot);
          wr_addr_d             = base_oth + AW'(slot);
          state_d               = swrl_pkg::ST_CLEAR;
        end else begin
          // any other gap: start afresh
          mode_d        = swrl_pkg::MODE_GAP;
          row_sec_d[0]  = secs_q;
          row_sec_d[1]  = secs_q;
          clr_addr_d    = '0;
          clr_left_d    = CW'(Depth);
          wr_addr_d     = base_cur + AW'(slot);
          wr_data_d     = CntW'(1);
          res_allowed_d = 1'b1;
          res_count_d   = CntW'(1);
          do_write_d    = 1'b1;
          state_d       = swrl_pkg::ST_CLEAR;
        end
      end

      swrl_pkg::ST_CLEAR: begin
        mem_we     = 1'b1;
        mem_waddr  = clr_addr_q;
        mem_wdata  = '0;
        clr_addr_d = clr_addr_q + AW'(1);
        clr_left_d = clr_left_q - CW'(1);
        if (clr_left_q == CW'(1)) begin
          state_d = (mode_q == swrl_pkg::MODE_NEXT) ? swrl_pkg::ST_WALK : swrl_pkg::ST_OUT;
        end
      end

      swrl_pkg::ST_WALK: begin
        // issue one read a cycle, stepping down through the flat address space
        if (rd_left_q != '0) begin
          rd_pend_d = 1'b1;
          rd_left_d = rd_left_q - RW'(1);
          rd_addr_d = (rd_addr_q == '0) ? AW'(Depth - 1) : rd_addr_q - AW'(1);
        end
        // accumulate returning counters
        if (rd_pend_q) begin
          first_d   = 1'b0;
          cur_val_d = cur_val_eff;
          sum_d     = sum_new;
        end
        if (rd_pend_q && (sum_new >= max_rate_q)) begin
          res_allowed_d = 1'b0;
          res_count_d   = sum_new;
          do_write_d    = 1'b0;
          state_d       = swrl_pkg::ST_OUT;
        end else if (rd_left_q == '0) begin
          res_allowed_d = 1'b1;
          res_count_d   = (rd_pend_q ? sum_new : sum_q) + CntW'(1);
          do_write_d    = 1'b1;
          wr_data_d     = (mode_q == swrl_pkg::MODE_SAME) ? cur_val_eff + CntW'(1)
                                                          : CntW'(1);
          state_d       = swrl_pkg::ST_OUT;
        end
      end

      swrl_pkg::ST_OUT: begin
        if (out_free) begin
          mem_we        = do_write_q;
          out_valid_d   = 1'b1;
          out_allowed_d = res_allowed_q;
          out_count_d   = res_count_q;
          state_d       = swrl_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = swrl_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= swrl_pkg::ST_IDLE;
      in_use_q    <= 1'b0;
      cur_row_q   <= 1'b0;
      max_rate_q  <= swrl_pkg::MaxRateRst;
      out_valid_q <= 1'b0;
      rd_pend_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      in_use_q    <= in_use_d;
      cur_row_q   <= cur_row_d;
      max_rate_q  <= max_rate_d;
      out_valid_q <= out_valid_d;
      rd_pend_q   <= rd_pend_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    mode_q        <= mode_d;
    row_sec_q     <= row_sec_d;
    secs_q        <= secs_d;
    millis_q      <= millis_d;
    clr_addr_q    <= clr_addr_d;
    clr_left_q    <= clr_left_d;
    rd_addr_q     <= rd_addr_d;
    rd_left_q     <= rd_left_d;
    first_q       <= first_d;
    sum_q         <= sum_d;
    cur_val_q     <= cur_val_d;
    res_allowed_q <= res_allowed_d;
    res_count_q   <= res_count_d;
    do_write_q    <= do_write_d;
    wr_addr_q     <= wr_addr_d;
    wr_data_q     <= wr_data_d;
    out_allowed_q <= out_allowed_d;
    out_count_q   <= out_count_d;
  end

  assign in_stall_o     = (state_q != swrl_pkg::ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign allowed_o      = out_allowed_q;
  assign window_count_o = out_count_q;
  assign cfg_ready_o    = 1'b1;

endmodule

// ===== test/tb_sliding_window_rate_limiter_unit.sv =====
`timescale 1ns / 1ps

module tb_sliding_window_rate_limiter_unit;

  localparam int unsigned SecW       = swrl_pkg::SecW;
  localparam int unsigned MillisW    = swrl_pkg::MillisW;
  localparam int unsigned CntW       = swrl_pkg::CntW;
  localparam int unsigned SLOTS      = 10;
  localparam int unsigned ClkPeriod  = 10;
  localparam int unsigned RstCycles  = 6;
  localparam int unsigned SettleCyc  = 40;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned NumPhases  = 12;
  localparam int unsigned PhaseItems = 155;
  localparam int unsigned DirRows    = 27;

  typedef enum logic {
    ROW_REQ = 1'b0,
    ROW_CFG = 1'b1
  } row_kind_e;

  // one directed row; for a config row cnt carries the new max_rate
  typedef struct packed {
    row_kind_e          kind;
    logic [SecW-1:0]    sec;
    logic [MillisW-1:0] ms;
    logic               typed;
    logic               ok;
    logic [CntW-1:0]    cnt;
  } row_t;

  typedef struct packed {
    logic            ok;
    logic [CntW-1:0] cnt;
  } verdict_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall_o;
  logic [SecW-1:0]    seconds = '0;
  logic [MillisW-1:0] millis = '0;
  logic               out_valid_o;
  logic               out_stall = 1'b0;
  logic               allowed_o;
  logic [CntW-1:0]    window_count_o;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready_o;
  logic [CntW-1:0]    cfg_rate = '0;

  // predictor state
  logic [CntW-1:0] slot_cnt [0:2*SLOTS-1];
  logic [SecW-1:0] row_sec [0:1];
  logic            cur_row;
  logic            live;
  logic [CntW-1:0] rate_limit;

  verdict_t verdict_q [$];
  row_t     dir_tab [0:DirRows-1];
  int       err_cnt = 0;
  int       cycle_cnt = 0;
  logic     offering = 1'b0;
  logic     no_idle = 1'b0;
  logic     hold_req = 1'b0;

  sliding_window_rate_limiter_unit #(
    .SLOTS(SLOTS)
  ) uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall_o),
    .seconds_i      (seconds),
    .millis_i       (millis),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall),
    .allowed_o      (allowed_o),
    .window_count_o (window_count_o),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_max_rate_i (cfg_rate)
  );

  always #(ClkPeriod / 2) clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic row_t req_row(input logic [SecW-1:0] s, input logic [MillisW-1:0] m);
    return '{ROW_REQ, s, m, 1'b0, 1'b0, {CntW{1'b0}}};
  endfunction

  function automatic row_t chk_row(input logic [SecW-1:0] s, input logic [MillisW-1:0] m,
                                   input logic ok, input logic [CntW-1:0] c);
    return '{ROW_REQ, s, m, 1'b1, ok, c};
  endfunction

  function automatic row_t cfg_row(input logic [CntW-1:0] v);
    return '{ROW_CFG, {SecW{1'b0}}, {MillisW{1'b0}}, 1'b0, 1'b0, v};
  endfunction

  // window decision for one request, updating the slot rows
  task automatic predict_window(input logic [SecW-1:0] sec, input logic [MillisW-1:0] ms,
                                output logic ok, output logic [CntW-1:0] cnt);
    int slot;
    int i;
    int j;
    int cb;
    int pb;
    logic [CntW-1:0] sum;
    logic hit;
    logic first;
    slot = (int'(ms) * SLOTS) / 1000;
    if (slot > SLOTS - 1) slot = SLOTS - 1;
    first = !live;
    if (first) begin
      for (i = 0; i < 2 * SLOTS; i++) slot_cnt[i] = '0;
      row_sec[0] = sec;
      row_sec[1] = sec;
      cur_row = 1'b0;
      live = 1'b1;
    end
    sum = '0;
    hit = 1'b0;
    cb = cur_row ? SLOTS : 0;
    pb = cur_row ? 0 : SLOTS;
    if (sec == row_sec[cur_row]) begin
      // same second: walk back across both rows
      i = slot;
      for (j = 0; j < SLOTS && !hit; j++) begin
        if (i < 0) sum = sum + slot_cnt[pb + SLOTS + i];
        else sum = sum + slot_cnt[cb + i];
        if (sum >= rate_limit) hit = 1'b1;
        i--;
      end
      if (!hit) begin
        slot_cnt[cb + slot] = slot_cnt[cb + slot] + 1'b1;
        sum = sum + 1'b1;
      end
    end else if (sec - row_sec[cur_row] == 32'd1) begin
      // next second: swap and clear, then the old row's later slots
      cur_row = ~cur_row;
      cb = cur_row ? SLOTS : 0;
      pb = cur_row ? 0 : SLOTS;
      row_sec[cur_row] = sec;
      for (i = 0; i < SLOTS; i++) slot_cnt[cb + i] = '0;
      for (i = SLOTS - 1; i > slot && !hit; i--) begin
        sum = sum + slot_cnt[pb + i];
        if (sum >= rate_limit) hit = 1'b1;
      end
      if (!hit) begin
        slot_cnt[cb + slot] = CntW'(1);
        sum = sum + 1'b1;
      end
    end else begin
      // any other gap starts afresh
      for (i = 0; i < 2 * SLOTS; i++) slot_cnt[i] = '0;
      row_sec[0] = sec;
      row_sec[1] = sec;
      slot_cnt[cb + slot] = CntW'(1);
      sum = CntW'(1);
    end
    ok = first ? 1'b1 : !hit;
    cnt = sum;
  endtask

  task automatic release_request();
    if (offering) in_valid <= 1'b0;
    offering = 1'b0;
  endtask

  // offer one request beat and record its verdict once taken
  task automatic send_request(input logic [SecW-1:0] sec, input logic [MillisW-1:0] ms,
                              input logic typed, input verdict_t typed_res);
    int gap;
    verdict_t res;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      release_request();
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    seconds  <= sec;
    millis   <= ms;
    offering = 1'b1;
    do @(posedge clk); while (in_stall_o);
    predict_window(sec, ms, res.ok, res.cnt);
    verdict_q.push_back(typed ? typed_res : res);
  endtask

  task automatic wait_drained();
    release_request();
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (SettleCyc) @(posedge clk);
  endtask

  // rate limit is only changed with the block idle
  task automatic write_rate(input logic [CntW-1:0] v);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_rate  <= v;
    do @(posedge clk); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    rate_limit = v;
  endtask

  // result side: random stalls and one long hold
  initial begin : result_sink
    int gap;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        hold_req = 1'b0;
      end
      gap = no_idle ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid_o);
    end
  end

  // compare each result beat with the oldest verdict
  always @(posedge clk) begin : check_results
    verdict_t want;
    if (rst_n && out_valid_o && !out_stall) begin
      if (verdict_q.size() == 0) begin
        $error("result beat with nothing pending: allowed %0d window_count %0d",
               allowed_o, window_count_o);
        err_cnt++;
      end else begin
        want = verdict_q.pop_front();
        if (allowed_o !== want.ok) begin
          $error("allowed: expected %0d, got %0d", want.ok, allowed_o);
          err_cnt++;
        end
        if (window_count_o !== want.cnt) begin
          $error("window_count: expected %0d, got %0d", want.cnt, window_count_o);
          err_cnt++;
        end
      end
    end
  end

  initial begin : stimulus
    int p;
    int k;
    int r;
    logic [SecW-1:0] base_sec;
    logic [SecW-1:0] sec;
    logic [MillisW-1:0] ms;
    logic [CntW-1:0] rate;
    verdict_t typed_res;

    for (k = 0; k < 2 * SLOTS; k++) slot_cnt[k] = '0;
    row_sec[0] = '0;
    row_sec[1] = '0;
    cur_row = 1'b0;
    live = 1'b0;
    rate_limit = swrl_pkg::MaxRateRst;

    repeat (RstCycles) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: first request at limit 0, saturated slot, second rollover, wrap, gaps
    dir_tab = '{
      cfg_row(16'd0),
      chk_row(32'd7, 10'd0, 1'b1, 16'd0),
      chk_row(32'd7, 10'd0, 1'b0, 16'd0),
      cfg_row(16'd100),
      chk_row(32'd7, 10'd0, 1'b1, 16'd1),
      chk_row(32'd7, 10'd999, 1'b1, 16'd2),
      chk_row(32'd7, 10'd1023, 1'b1, 16'd3),
      req_row(32'd7, 10'd500),
      req_row(32'd8, 10'd0),
      req_row(32'd8, 10'd999),
      chk_row(32'd10, 10'd0, 1'b1, 16'd1),
      req_row(32'd11, 10'd300),
      cfg_row(16'd2),
      req_row(32'd11, 10'd300),
      req_row(32'd11, 10'd300),
      req_row(32'd12, 10'd999),
      cfg_row(16'd0),
      chk_row(32'd12, 10'd999, 1'b0, 16'd1),
      req_row(32'd13, 10'd999),
      req_row(32'd14, 10'd0),
      cfg_row(16'hFFFF),
      chk_row(32'hFFFF_FFFF, 10'd0, 1'b1, 16'd1),
      req_row(32'd0, 10'd999),
      chk_row(32'hFFFF_FFFF, 10'd500, 1'b1, 16'd1),
      chk_row(32'h8000_0000, 10'd1000, 1'b1, 16'd1),
      req_row(32'h8000_0000, 10'd1023),
      req_row(32'h8000_0001, 10'd1)
    };
    foreach (dir_tab[n]) begin
      if (dir_tab[n].kind == ROW_CFG) begin
        write_rate(dir_tab[n].cnt);
      end else begin
        typed_res = '{dir_tab[n].ok, dir_tab[n].cnt};
        send_request(dir_tab[n].sec, dir_tab[n].ms, dir_tab[n].typed, typed_res);
      end
    end

    // random phases, each under its own rate limit
    base_sec = $urandom;
    typed_res = '0;
    for (p = 0; p < NumPhases; p++) begin
      case (p)
        0: rate = 16'd1;
        1: rate = 16'd0;
        2: rate = 16'hFFFF;
        3: rate = 16'd3;
        4: rate = 16'($urandom_range(0, 65535));
        5: rate = 16'd2;
        default: rate = 16'($urandom_range(1, 40));
      endcase
      write_rate(rate);
      no_idle = (p == 5 || p == 9);
      if (p == 3) hold_req = 1'b1;
      for (k = 0; k < PhaseItems; k++) begin
        // pause until every verdict is back, then carry on
        if (p == 7 && k == PhaseItems / 2) wait_drained();
        r = $urandom_range(0, 99);
        if (r < 55) sec = base_sec;
        else if (r < 80) sec = base_sec + 1;
        else if (r < 86) sec = base_sec - 1;
        else if (r < 92) sec = base_sec + $urandom_range(2, 5);
        else sec = $urandom;
        base_sec = sec;
        if ($urandom_range(0, 99) < 6) ms = 10'($urandom_range(1000, 1023));
        else ms = 10'($urandom_range(0, 999));
        send_request(sec, ms, 1'b0, typed_res);
      end
    end
    no_idle = 1'b0;

    wait_drained();
    if (err_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
